@@ src/assert_macros.svh @@
// assertion macros for the top level rtl file of the bit vector block
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked check, disabled while reset is asserted
`define BSO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked check that also holds during reset
`define BSO_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define BSO_ASSERT(lbl, clk, rst_n, prop, msg)
`define BSO_ASSERT_NORST(lbl, clk, prop, msg)

`endif

`endif

@@ src/bso_pkg.sv @@
// shared types and constants of the bit vector block
// no dependencies
package bso_pkg;

    // storage word and field widths
    localparam int WORD_BITS = 64;
    localparam int POS_W     = 6;
    localparam int LEN_CFG_W = 13;
    localparam int IDX_W     = 12;
    localparam int SHIFT_W   = 13;

    // length register after reset
    localparam logic [LEN_CFG_W-1:0] LEN_RESET = 13'd4096;

    // operation codes of an input item
    localparam logic [1:0] IN_WRITE = 2'd0;
    localparam logic [1:0] IN_READ  = 2'd1;
    localparam logic [1:0] IN_SHIFT = 2'd2;
    localparam logic [1:0] IN_CLEAR = 2'd3;

    // work codes handed from front to back; mask is the length trim pass
    typedef enum logic [2:0] {
        OP_NOP,
        OP_WRITE,
        OP_READ,
        OP_SHIFT,
        OP_CLEAR,
        OP_MASK
    } t_op;

    // back end status seen by the front end and the top level
    typedef struct packed {
        logic init;
        logic done;
    } t_back_stat;

endpackage

@@ src/bso_ram.sv @@
// generic one write, two read port ram with registered read data
// no dependencies
module bso_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr_a,
    input  logic [AW-1:0]    i_rd_addr_b,
    output logic [WIDTH-1:0] o_rd_data_a,
    output logic [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // write port and both registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

@@ src/bso_front.sv @@
// front end: takes input items, checks index and shift range, builds commands
// depends on bso_pkg
module bso_front #(
    parameter int MAX_BITS = 4096,
    localparam int NWORDS = (MAX_BITS + bso_pkg::WORD_BITS - 1) / bso_pkg::WORD_BITS,
    localparam int AW = (NWORDS > 1) ? $clog2(NWORDS) : 1,
    localparam int EL_W = ($clog2(MAX_BITS + 1) > bso_pkg::LEN_CFG_W) ?
                          $clog2(MAX_BITS + 1) : bso_pkg::LEN_CFG_W,
    localparam int CMD_W = $bits(bso_pkg::t_op) + 1 + AW + bso_pkg::POS_W + 1
) (
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_op,
    input  logic [bso_pkg::IDX_W-1:0]    i_bit_index,
    input  logic                         i_bit_value,
    input  logic [bso_pkg::SHIFT_W-1:0]  i_shift_amount,
    input  logic [EL_W-1:0]              i_eff_len,
    input  bso_pkg::t_back_stat          i_stat,
    input  logic                         i_q_full,
    output logic                         o_push,
    output logic [CMD_W-1:0]             o_cmd
);

    typedef struct packed {
        bso_pkg::t_op                op;
        logic                        err;
        logic [AW-1:0]               addr;
        logic [bso_pkg::POS_W-1:0]   pos;
        logic                        val;
    } t_cmd;

    t_cmd cmd;
    logic idx_err;
    logic shift_nop;

    // range checks against the effective length
    assign idx_err   = (EL_W'(i_bit_index) >= i_eff_len);
    assign shift_nop = (i_shift_amount == '0) || (EL_W'(i_shift_amount) >= i_eff_len);

    // classify the item
    always_comb begin
        cmd.op   = bso_pkg::OP_NOP;
        cmd.err  = 1'b0;
        cmd.addr = AW'(i_bit_index >> bso_pkg::POS_W);
        cmd.pos  = i_bit_index[bso_pkg::POS_W-1:0];
        cmd.val  = i_bit_value;
        case (i_op)
            bso_pkg::IN_WRITE: begin
                cmd.err = idx_err;
                if (!idx_err) begin
                    cmd.op = bso_pkg::OP_WRITE;
                end
            end
            bso_pkg::IN_READ: begin
                cmd.err = idx_err;
                if (!idx_err) begin
                    cmd.op = bso_pkg::OP_READ;
                end
            end
            bso_pkg::IN_SHIFT: begin
                cmd.addr = AW'(i_shift_amount >> bso_pkg::POS_W);
                cmd.pos  = i_shift_amount[bso_pkg::POS_W-1:0];
                if (!shift_nop) begin
                    cmd.op = bso_pkg::OP_SHIFT;
                end
            end
            bso_pkg::IN_CLEAR: begin
                cmd.op = bso_pkg::OP_CLEAR;
            end
            default: begin
                cmd.op = bso_pkg::OP_NOP;
            end
        endcase
    end

    // hold off while the queue is full or the reset clear runs
    assign o_in_stall = i_q_full || i_stat.init;
    assign o_push     = i_in_valid && !o_in_stall;
    assign o_cmd      = cmd;

endmodule

@@ src/bso_queue.sv @@
// two-entry command queue between front and back end
// no dependencies
module bso_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_slot[r_rd_ptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

@@ src/bso_back.sv @@
// back end: word sequencer over the bit vector ram, result register
// depends on bso_pkg and bso_ram
module bso_back #(
    parameter int MAX_BITS = 4096,
    localparam int NWORDS = (MAX_BITS + bso_pkg::WORD_BITS - 1) / bso_pkg::WORD_BITS,
    localparam int AW = (NWORDS > 1) ? $clog2(NWORDS) : 1,
    localparam int EL_W = ($clog2(MAX_BITS + 1) > bso_pkg::LEN_CFG_W) ?
                          $clog2(MAX_BITS + 1) : bso_pkg::LEN_CFG_W,
    localparam int CMD_W = $bits(bso_pkg::t_op) + 1 + AW + bso_pkg::POS_W + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic                 i_q_empty,
    output logic                 o_pop,
    input  logic                 i_cfg_we,
    input  logic [EL_W-1:0]      i_new_len,
    input  logic [EL_W-1:0]      i_eff_len,
    output bso_pkg::t_back_stat  o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_read_bit,
    output logic                 o_index_error
);

    localparam int WB = bso_pkg::WORD_BITS;
    localparam int PW = bso_pkg::POS_W;
    localparam int LW = AW + 1;
    localparam logic [AW-1:0] TOP_ADDR  = AW'(NWORDS - 1);
    localparam logic [LW-1:0] ALL_STEPS = LW'(NWORDS);

    typedef struct packed {
        bso_pkg::t_op      op;
        logic              err;
        logic [AW-1:0]     addr;
        logic [PW-1:0]     pos;
        logic              val;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    t_cmd          cmd;
    t_state        r_state;
    bso_pkg::t_op  r_mode;
    logic          r_init;
    logic          r_pend;
    logic [EL_W-1:0] r_clip;
    logic [AW-1:0] r_dst;
    logic [AW-1:0] r_src;
    logic [LW-1:0] r_left;
    logic [PW-1:0] r_pos;
    logic          r_val;
    logic          r_s1_vld;
    logic          r_s1_last;
    logic [AW-1:0] r_s1_dst;
    logic          r_s2_vld;
    logic          r_s2_last;
    logic [AW-1:0] r_s2_dst;
    logic [WB-1:0] r_s2_a;
    logic [WB-1:0] r_s2_b;
    logic          r_res_bit;
    logic          r_res_err;
    logic          r_out_vld;
    logic          r_out_bit;
    logic          r_out_err;

    logic [WB-1:0] rd_a;
    logic [WB-1:0] rd_b;
    logic [WB-1:0] lo;
    logic [WB-1:0] hi;
    logic [WB-1:0] wr_data;
    logic          wr_en;
    logic          start_mask;
    logic          start_cmd;
    logic          cfg_take;
    logic          mask_busy;
    logic          out_free;
    logic [EL_W-1:0] clip_min;

    // bits of word addr that lie below len
    function automatic logic [WB-1:0] len_mask(input logic [AW-1:0] addr,
                                               input logic [EL_W-1:0] len);
        logic [EL_W-PW-1:0] lw;
        logic [EL_W-PW-1:0] ax;
        logic [PW-1:0]      lb;
        logic [WB-1:0]      m;
        lw = len[EL_W-1:PW];
        lb = len[PW-1:0];
        ax = (EL_W-PW)'(addr);
        if (ax < lw) begin
            m = '1;
        end else if (ax == lw) begin
            m = (WB'(1) << lb) - WB'(1);
        end else begin
            m = '0;
        end
        return m;
    endfunction

    assign cmd = t_cmd'(i_cmd);

    // command start and config bookkeeping
    assign start_mask = (r_state == ST_IDLE) && r_pend;
    assign start_cmd  = (r_state == ST_IDLE) && !r_pend && !i_q_empty;
    assign o_pop      = start_cmd;
    assign cfg_take   = i_cfg_we && !r_init;
    assign mask_busy  = r_pend || ((r_mode == bso_pkg::OP_MASK) && (r_state != ST_IDLE));
    assign clip_min   = (i_new_len < r_clip) ? i_new_len : r_clip;
    assign out_free   = !r_out_vld || !i_out_stall;

    // shifted source word: low part from this word, carry from the one below
    assign lo = r_s2_b << r_pos;
    assign hi = r_s2_last ? '0 : ((rd_b >> 1) >> (PW'(WB - 1) - r_pos));

    // write-back word for the current mode
    always_comb begin
        wr_en = r_s2_vld;
        case (r_mode)
            bso_pkg::OP_WRITE: begin
                wr_data = (r_s2_a & ~(WB'(1) << r_pos)) | (WB'(r_val) << r_pos);
            end
            bso_pkg::OP_SHIFT: begin
                wr_data = (r_s2_a | lo | hi) & len_mask(r_s2_dst, i_eff_len);
            end
            bso_pkg::OP_MASK: begin
                wr_data = r_s2_a & len_mask(r_s2_dst, r_clip);
            end
            bso_pkg::OP_CLEAR: begin
                wr_data = '0;
            end
            default: begin
                wr_data = r_s2_a;
                wr_en   = 1'b0;
            end
        endcase
    end

    bso_ram #(
        .WIDTH(WB),
        .DEPTH(NWORDS)
    ) u_ram (
        .i_clk       (i_clk),
        .i_we        (wr_en),
        .i_wr_addr   (r_s2_dst),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (r_dst),
        .i_rd_addr_b (r_src),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    // sequencer, word pipeline and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RUN;
            r_mode    <= bso_pkg::OP_CLEAR;
            r_init    <= 1'b1;
            r_pend    <= 1'b0;
            r_clip    <= '0;
            r_dst     <= TOP_ADDR;
            r_src     <= TOP_ADDR;
            r_left    <= ALL_STEPS;
            r_s1_vld  <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s2_last <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // pipeline: issue, ram data, write-back
            r_s1_vld  <= (r_state == ST_RUN);
            r_s1_last <= (r_left == LW'(1));
            r_s1_dst  <= r_dst;
            r_s2_vld  <= r_s1_vld;
            r_s2_last <= r_s1_last;
            r_s2_dst  <= r_s1_dst;
            r_s2_a    <= rd_a;
            r_s2_b    <= rd_b;

            // a length write outside the clearing pass queues a trim pass at the smallest pending length
            if (cfg_take) begin
                r_clip <= mask_busy ? clip_min : i_new_len;
            end
            r_pend <= (r_pend && !start_mask) || cfg_take;

            if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (start_mask) begin
                        r_mode  <= bso_pkg::OP_MASK;
                        r_dst   <= TOP_ADDR;
                        r_src   <= TOP_ADDR;
                        r_left  <= ALL_STEPS;
                        r_state <= ST_RUN;
                    end else if (start_cmd) begin
                        r_mode    <= cmd.op;
                        r_pos     <= cmd.pos;
                        r_val     <= cmd.val;
                        r_res_err <= cmd.err;
                        r_res_bit <= 1'b0;
                        case (cmd.op)
                            bso_pkg::OP_WRITE, bso_pkg::OP_READ: begin
                                r_dst   <= cmd.addr;
                                r_src   <= cmd.addr;
                                r_left  <= LW'(1);
                                r_state <= ST_RUN;
                            end
                            bso_pkg::OP_SHIFT: begin
                                r_dst   <= TOP_ADDR;
                                r_src   <= TOP_ADDR - cmd.addr;
                                r_left  <= ALL_STEPS - LW'(cmd.addr);
                                r_state <= ST_RUN;
                            end
                            bso_pkg::OP_CLEAR: begin
                                r_dst   <= TOP_ADDR;
                                r_src   <= TOP_ADDR;
                                r_left  <= ALL_STEPS;
                                r_state <= ST_RUN;
                            end
                            default: begin
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_RUN: begin
                    r_dst  <= r_dst - AW'(1);
                    r_src  <= r_src - AW'(1);
                    r_left <= r_left - LW'(1);
                    if (r_left == LW'(1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (r_s2_vld && r_s2_last) begin
                        if (r_init || (r_mode == bso_pkg::OP_MASK)) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_DONE;
                        end
                        r_init <= 1'b0;
                        if (r_mode == bso_pkg::OP_READ) begin
                            r_res_bit <= r_s2_a[r_pos];
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_out_bit <= r_res_bit;
                        r_out_err <= r_res_err;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stat.init   = r_init;
    assign o_stat.done   = (r_state == ST_DONE);
    assign o_out_valid   = r_out_vld;
    assign o_read_bit    = r_out_bit;
    assign o_index_error = r_out_err;

endmodule

@@ src/bitset_shift_or_store.sv @@
// bit vector with write, read, clear and shift-or; depends on bso_pkg, bso_front,
// bso_queue, bso_back and assert_macros.svh. an item runs alone in the back end;
// each sweep moves one 64-bit ram word per cycle. reset runs a clearing pass with
// no item taken; a length write after it queues a trim pass ahead of the items
// that follow it.
`include "assert_macros.svh"

module bitset_shift_or_store #(
    parameter int MAX_BITS = 4096,
    localparam int NWORDS = (MAX_BITS + bso_pkg::WORD_BITS - 1) / bso_pkg::WORD_BITS,
    localparam int AW = (NWORDS > 1) ? $clog2(NWORDS) : 1,
    localparam int EL_W = ($clog2(MAX_BITS + 1) > bso_pkg::LEN_CFG_W) ?
                          $clog2(MAX_BITS + 1) : bso_pkg::LEN_CFG_W,
    localparam int CMD_W = $bits(bso_pkg::t_op) + 1 + AW + bso_pkg::POS_W + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_op,
    input  logic [bso_pkg::IDX_W-1:0]      i_bit_index,
    input  logic                           i_bit_value,
    input  logic [bso_pkg::SHIFT_W-1:0]    i_shift_amount,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_read_bit,
    output logic                           o_index_error,
    input  logic                           i_cfg_wr_en,
    input  logic [bso_pkg::LEN_CFG_W-1:0]  i_cfg_wr_data
);

    logic [bso_pkg::LEN_CFG_W-1:0] r_length;
    logic [EL_W-1:0]               eff_len;
    logic [EL_W-1:0]               new_len;
    logic [CMD_W-1:0]              front_cmd;
    logic [CMD_W-1:0]              head_cmd;
    logic                          push;
    logic                          pop;
    logic                          q_full;
    logic                          q_empty;
    bso_pkg::t_back_stat           bstat;

    // length clamped to the storage size
    function automatic logic [EL_W-1:0] clamp_len(input logic [bso_pkg::LEN_CFG_W-1:0] len);
        logic [EL_W-1:0] ext;
        ext = EL_W'(len);
        return (ext > EL_W'(MAX_BITS)) ? EL_W'(MAX_BITS) : ext;
    endfunction

    // length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= bso_pkg::LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_length <= i_cfg_wr_data;
        end
    end

    assign eff_len = clamp_len(r_length);
    assign new_len = clamp_len(i_cfg_wr_data);

    bso_front #(
        .MAX_BITS(MAX_BITS)
    ) u_front (
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_bit_index    (i_bit_index),
        .i_bit_value    (i_bit_value),
        .i_shift_amount (i_shift_amount),
        .i_eff_len      (eff_len),
        .i_stat         (bstat),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    bso_queue #(
        .WIDTH(CMD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_empty (q_empty)
    );

    bso_back #(
        .MAX_BITS(MAX_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_q_empty     (q_empty),
        .o_pop         (pop),
        .i_cfg_we      (i_cfg_wr_en),
        .i_new_len     (new_len),
        .i_eff_len     (eff_len),
        .o_stat        (bstat),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_bit    (o_read_bit),
        .o_index_error (o_index_error)
    );

    // checks
    `BSO_ASSERT_NORST(a_reset_starts_clear, i_clk, !i_rst_n |=> bstat.init, "reset did not start the clearing pass")
    `BSO_ASSERT(a_clear_holds_input, i_clk, i_rst_n, bstat.init |-> (o_in_stall && q_empty), "item taken during the clearing pass")
    `BSO_ASSERT(a_result_after_done, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(bstat.done), "result shown without a finished item")

endmodule
